@@ hw/rtl/pfb_pkg.sv @@
// Shared types and constants for the page framebuffer glyph blitter.
`default_nettype none

package pfb_pkg;

  // Default geometry
  localparam int unsigned DefDisplayWidth  = 128;
  localparam int unsigned DefDisplayHeight = 64;
  localparam int unsigned DefChunkBytes    = 16;
  localparam int unsigned DefBarLeft       = 40;
  localparam int unsigned DefStoreBytes    = DefDisplayWidth * ((DefDisplayHeight + 7) / 8);

  // Datapath widths fixed by the field ranges
  localparam int unsigned AluW  = 16;  // shared adder / comparator
  localparam int unsigned ColW  = 9;   // column, up to 255 + 7
  localparam int unsigned PageW = 6;   // page, up to 31 + 1
  localparam int unsigned KW    = 4;   // byte slot within a chunk read

  localparam int unsigned MaxReadCount = 16;
  localparam int unsigned PercentFull  = 100;
  localparam int unsigned BarTopGap    = 12;
  localparam logic [2:0]  GlyphLastCol = 3'd7;

  typedef enum logic [1:0] {
    OpClear = 2'd0,
    OpGlyph = 2'd1,
    OpBar   = 2'd2,
    OpRead  = 2'd3
  } pfb_op_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  x_pos;
    logic [7:0]  y_pos;
    logic [63:0] glyph_bits;
    logic [7:0]  score;
    logic [5:0]  chunk_index;
  } pfb_cmd_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [9:0] byte_index;
    logic       last_of_chunk;
  } pfb_res_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } pfb_mem_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/pfb_alu.sv @@
// Shared add-and-compare unit used by the bar-extent, column, byte-address and read-address steps.
`default_nettype none

module pfb_alu (
  input  logic [pfb_pkg::AluW-1:0] a_i,
  input  logic [pfb_pkg::AluW-1:0] b_i,
  input  logic [pfb_pkg::AluW-1:0] lim_i,
  output logic [pfb_pkg::AluW-1:0] sum_o,
  output logic                     lt_o
);
  import pfb_pkg::*;

  assign sum_o = a_i + b_i;
  assign lt_o  = (sum_o < lim_i);

endmodule

`default_nettype wire

@@ hw/rtl/pfb_store.sv @@
// Framebuffer memory: one write port, one registered read port.
`default_nettype none

module pfb_store #(
  parameter  int unsigned DEPTH = pfb_pkg::DefStoreBytes,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  pfb_pkg::pfb_mem_ctl_t ctl_i,
  input  logic [AddrW-1:0]      waddr_i,
  input  logic [7:0]            wdata_i,
  input  logic [AddrW-1:0]      raddr_i,
  output logic [7:0]            rdata_o
);
  import pfb_pkg::*;

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hw/rtl/pfb_ctrl.sv @@
// Sequencer: clear sweep, glyph and bar read-modify-write, chunk readout.
`default_nettype none

module pfb_ctrl #(
  parameter  int unsigned DISPLAY_WIDTH  = pfb_pkg::DefDisplayWidth,
  parameter  int unsigned DISPLAY_HEIGHT = pfb_pkg::DefDisplayHeight,
  parameter  int unsigned CHUNK_BYTES    = pfb_pkg::DefChunkBytes,
  parameter  int unsigned BAR_LEFT       = pfb_pkg::DefBarLeft,
  localparam int unsigned AddrW = $clog2(DISPLAY_WIDTH * ((DISPLAY_HEIGHT + 7) / 8))
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  pfb_pkg::pfb_cmd_t         cmd_i,
  output logic [pfb_pkg::AluW-1:0]  alu_a_o,
  output logic [pfb_pkg::AluW-1:0]  alu_b_o,
  output logic [pfb_pkg::AluW-1:0]  alu_lim_o,
  input  logic [pfb_pkg::AluW-1:0]  alu_sum_i,
  input  logic                      alu_lt_i,
  output pfb_pkg::pfb_mem_ctl_t     mem_ctl_o,
  output logic [AddrW-1:0]          mem_waddr_o,
  output logic [7:0]                mem_wdata_o,
  output logic [AddrW-1:0]          mem_raddr_o,
  input  logic [7:0]                mem_rdata_i,
  output logic                      result_valid_o,
  output pfb_pkg::pfb_res_t         res_o
);
  import pfb_pkg::*;

  localparam int unsigned PageCount  = (DISPLAY_HEIGHT + 7) / 8;
  localparam int unsigned StoreBytes = DISPLAY_WIDTH * PageCount;
  localparam int unsigned ReadCount  = (CHUNK_BYTES > MaxReadCount) ? MaxReadCount : CHUNK_BYTES;
  localparam int unsigned BarTop     = DISPLAY_HEIGHT - BarTopGap;

  localparam logic [PageW-1:0] BarPage   = PageW'(BarTop / 8);
  localparam logic [2:0]       BarShift  = 3'(BarTop % 8);
  localparam logic [ColW-1:0]  BarLeftW  = ColW'(BAR_LEFT);
  localparam logic [8:0]       HeightW   = 9'(DISPLAY_HEIGHT);
  localparam logic [AluW-1:0]  WidthW    = AluW'(DISPLAY_WIDTH);
  localparam logic [AluW-1:0]  StoreW    = AluW'(StoreBytes);
  localparam logic [AluW-1:0]  BarSpanW  = AluW'(DISPLAY_WIDTH - 2);
  localparam logic [AluW-1:0]  PctW      = AluW'(PercentFull);
  localparam logic [AluW-1:0]  ChunkW    = AluW'(CHUNK_BYTES);
  localparam logic [AddrW-1:0] ClrLast   = AddrW'(StoreBytes - 1);
  localparam logic [KW-1:0]    LastK     = KW'(ReadCount - 1);

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StBarChk,
    StCol,
    StByte,
    StWrite,
    StRdIssue,
    StRdOut
  } state_e;

  state_e              state_q;
  pfb_op_e             op_q;
  logic [ColW-1:0]     colbase_q;
  logic [PageW-1:0]    page0_q;
  logic [2:0]          sh_q;
  logic [63:0]         glyph_q;
  logic [AluW-1:0]     plim_q;
  logic [AluW-1:0]     acc_q;
  logic [AluW-1:0]     base_q;
  logic [ColW-1:0]     cnt_q;
  logic                half_q;
  logic [ColW-1:0]     col_q;
  logic [AddrW-1:0]    addr_q;
  logic [7:0]          mask_q;
  logic [7:0]          val_q;
  logic [AddrW-1:0]    clr_q;
  logic [KW-1:0]       k_q;
  logic [9:0]          idx_q;
  logic                inr_q;

  logic [7:0]          colbits;
  logic [15:0]         m16;
  logic [15:0]         v16;
  logic [PageW-1:0]    page;
  logic [7:0]          rowmask;
  logic [7:0]          m8;
  logic [7:0]          v8;
  logic [AluW-1:0]     page_base;
  logic [6:0]          pct;
  logic [AluW-1:0]     plim_start;
  logic [AluW-1:0]     base_start;
  state_e              col_next;
  logic                accept;

  assign accept = start_i && (state_q == StIdle);

  // Column slice of the glyph (or a full bar column), shifted into the two pages it may touch
  always_comb begin
    for (int r = 0; r < 8; r++) begin
      colbits[r] = glyph_q[{3'(r), cnt_q[2:0]}];
    end
    m16 = 16'h00FF << sh_q;
    v16 = ((op_q == OpGlyph) ? {8'h00, colbits} : 16'h00FF) << sh_q;
    page = page0_q + PageW'(half_q);
    for (int k = 0; k < 8; k++) begin
      rowmask[k] = ({page, 3'(k)} < HeightW);
    end
    m8 = (half_q ? m16[15:8] : m16[7:0]) & rowmask;
    v8 = (half_q ? v16[15:8] : v16[7:0]) & m8;
    page_base = AluW'(page) * WidthW;
  end

  always_comb begin
    pct        = (cmd_i.score > 8'(PercentFull)) ? 7'(PercentFull) : cmd_i.score[6:0];
    plim_start = AluW'(pct) * BarSpanW + AluW'(1);
    base_start = AluW'(cmd_i.chunk_index) * ChunkW;
    if (op_q == OpBar) begin
      col_next = StBarChk;
    end else if (cnt_q[2:0] == GlyphLastCol) begin
      col_next = StIdle;
    end else begin
      col_next = StCol;
    end
  end

  // Shared unit operands
  always_comb begin
    unique case (state_q)
      StBarChk: begin
        alu_a_o   = acc_q;
        alu_b_o   = PctW;
        alu_lim_o = plim_q;
      end
      StCol: begin
        alu_a_o   = AluW'(colbase_q);
        alu_b_o   = AluW'(cnt_q);
        alu_lim_o = WidthW;
      end
      StByte: begin
        alu_a_o   = page_base;
        alu_b_o   = AluW'(col_q);
        alu_lim_o = '0;
      end
      StRdIssue: begin
        alu_a_o   = base_q;
        alu_b_o   = AluW'(k_q);
        alu_lim_o = StoreW;
      end
      default: begin
        alu_a_o   = '0;
        alu_b_o   = '0;
        alu_lim_o = '0;
      end
    endcase
  end

  always_comb begin
    mem_ctl_o.wr_en = (state_q == StClear) || (state_q == StWrite);
    mem_ctl_o.rd_en = ((state_q == StByte) && (m8 != 8'h00)) ||
                      ((state_q == StRdIssue) && alu_lt_i);
    mem_waddr_o     = (state_q == StClear) ? clr_q : addr_q;
    mem_wdata_o     = (state_q == StClear) ? 8'h00 : ((mem_rdata_i & ~mask_q) | val_q);
    mem_raddr_o     = alu_sum_i[AddrW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StClear;
      op_q      <= OpClear;
      colbase_q <= '0;
      page0_q   <= '0;
      sh_q      <= '0;
      glyph_q   <= '0;
      plim_q    <= '0;
      acc_q     <= '0;
      base_q    <= '0;
      cnt_q     <= '0;
      half_q    <= 1'b0;
      col_q     <= '0;
      addr_q    <= '0;
      mask_q    <= '0;
      val_q     <= '0;
      clr_q     <= '0;
      k_q       <= '0;
      idx_q     <= '0;
      inr_q     <= 1'b0;
    end else begin
      unique case (state_q)
        StClear: begin
          if (clr_q == ClrLast) begin
            state_q <= StIdle;
          end else begin
            clr_q <= clr_q + AddrW'(1);
          end
        end
        StIdle: begin
          if (accept) begin
            op_q  <= pfb_op_e'(cmd_i.command);
            cnt_q <= '0;
            unique case (pfb_op_e'(cmd_i.command))
              OpClear: begin
                clr_q   <= '0;
                state_q <= StClear;
              end
              OpGlyph: begin
                colbase_q <= ColW'(cmd_i.x_pos);
                page0_q   <= PageW'(cmd_i.y_pos[7:3]);
                sh_q      <= cmd_i.y_pos[2:0];
                glyph_q   <= cmd_i.glyph_bits;
                state_q   <= StCol;
              end
              OpBar: begin
                colbase_q <= BarLeftW;
                page0_q   <= BarPage;
                sh_q      <= BarShift;
                plim_q    <= plim_start;
                acc_q     <= '0;
                state_q   <= StBarChk;
              end
              OpRead: begin
                base_q  <= base_start;
                k_q     <= '0;
                state_q <= StRdIssue;
              end
              default: state_q <= StIdle;
            endcase
          end
        end
        StBarChk: begin
          // Column c is in the bar while (c+1)*100 <= pct*(width-2)
          if (alu_lt_i) begin
            acc_q   <= alu_sum_i;
            state_q <= StCol;
          end else begin
            state_q <= StIdle;
          end
        end
        StCol: begin
          if (alu_lt_i) begin
            col_q   <= alu_sum_i[ColW-1:0];
            half_q  <= 1'b0;
            state_q <= StByte;
          end else begin
            state_q <= StIdle;
          end
        end
        StByte: begin
          if (m8 != 8'h00) begin
            addr_q  <= alu_sum_i[AddrW-1:0];
            mask_q  <= m8;
            val_q   <= v8;
            state_q <= StWrite;
          end else if (!half_q) begin
            half_q <= 1'b1;
          end else begin
            cnt_q   <= cnt_q + ColW'(1);
            state_q <= col_next;
          end
        end
        StWrite: begin
          if (!half_q) begin
            half_q  <= 1'b1;
            state_q <= StByte;
          end else begin
            cnt_q   <= cnt_q + ColW'(1);
            state_q <= col_next;
          end
        end
        StRdIssue: begin
          idx_q   <= alu_sum_i[9:0];
          inr_q   <= alu_lt_i;
          state_q <= StRdOut;
        end
        StRdOut: begin
          k_q <= k_q + KW'(1);
          state_q <= (k_q == LastK) ? StIdle : StRdIssue;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign busy_o               = (state_q != StIdle);
  assign result_valid_o       = (state_q == StRdOut);
  assign res_o.data_byte      = inr_q ? mem_rdata_i : 8'h00;
  assign res_o.byte_index     = idx_q;
  assign res_o.last_of_chunk  = result_valid_o && (k_q == LastK);

  a_beat_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result beats back to back");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_ctl_o.wr_en && mem_ctl_o.rd_en))
    else $error("read and write in one cycle");

  a_wr_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWrite) |-> $past(mem_ctl_o.rd_en))
    else $error("merge write without preceding read");

  a_accept_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> !result_valid_o)
    else $error("result beat right after accept");

  a_waddr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_ctl_o.wr_en |-> (int'(mem_waddr_o) < StoreBytes))
    else $error("write beyond framebuffer");

endmodule

`default_nettype wire

@@ hw/rtl/page_framebuffer_glyph_blitter.sv @@
// Top level of the page framebuffer glyph blitter.
//
//   channel   direction  handshake             payload
//   command   in         start_i, busy_o       cmd_i  (pfb_cmd_t)
//   result    out        result_valid_o        res_o  (pfb_res_t)
//
// Clear writes zero to every framebuffer byte, one byte written per cycle.
// Glyph: per column one bounds step and, for each of its two pages, a byte step (a read
// when the page is touched) and, per touched page, a merge-write on the framebuffer memory.
// Bar works per lit column: extent step, bounds step, two merges.
// Read chunk alternates per beat between a memory read and the beat on res_o.
// After reset the same clear sweep runs, with busy_o high until it ends.
// Result beats last one cycle and are not held; the receiver cannot stall.
`default_nettype none

module page_framebuffer_glyph_blitter #(
  parameter int unsigned DISPLAY_WIDTH  = pfb_pkg::DefDisplayWidth,
  parameter int unsigned DISPLAY_HEIGHT = pfb_pkg::DefDisplayHeight,
  parameter int unsigned CHUNK_BYTES    = pfb_pkg::DefChunkBytes,
  parameter int unsigned BAR_LEFT       = pfb_pkg::DefBarLeft
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  pfb_pkg::pfb_cmd_t cmd_i,
  output logic              result_valid_o,
  output pfb_pkg::pfb_res_t res_o
);
  import pfb_pkg::*;

  localparam int unsigned StoreBytes = DISPLAY_WIDTH * ((DISPLAY_HEIGHT + 7) / 8);
  localparam int unsigned AddrW      = $clog2(StoreBytes);

  logic [AluW-1:0]  alu_a;
  logic [AluW-1:0]  alu_b;
  logic [AluW-1:0]  alu_lim;
  logic [AluW-1:0]  alu_sum;
  logic             alu_lt;
  pfb_mem_ctl_t     mem_ctl;
  logic [AddrW-1:0] mem_waddr;
  logic [7:0]       mem_wdata;
  logic [AddrW-1:0] mem_raddr;
  logic [7:0]       mem_rdata;

  pfb_ctrl #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT),
    .CHUNK_BYTES    (CHUNK_BYTES),
    .BAR_LEFT       (BAR_LEFT)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .cmd_i          (cmd_i),
    .alu_a_o        (alu_a),
    .alu_b_o        (alu_b),
    .alu_lim_o      (alu_lim),
    .alu_sum_i      (alu_sum),
    .alu_lt_i       (alu_lt),
    .mem_ctl_o      (mem_ctl),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata),
    .result_valid_o (result_valid_o),
    .res_o          (res_o)
  );

  pfb_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .lim_i (alu_lim),
    .sum_o (alu_sum),
    .lt_o  (alu_lt)
  );

  pfb_store #(
    .DEPTH (StoreBytes)
  ) u_store (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire
